>>> hdl/sha1sh_pkg.sv
package sha1sh_pkg;

  // Input item: one message byte and its flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  // Result item: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Round function groups, twenty rounds each
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } round_grp_t;

  localparam int unsigned NumRounds   = 80;
  localparam int unsigned GroupRounds = 20;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned LenStart    = 56;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_CHAIN [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift;
    byte_sel_t  byte_sel;
    logic       count;
    logic       load_work;
    logic       round_step;
    round_grp_t round_grp;
    logic       fold;
    logic       out_load;
    logic [2:0] out_idx;
    logic       init;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] blk_pos;
    logic       out_full;
  } stat_t;

endpackage

>>> hdl/sha1_stream_hasher_core.sv
// Channel | Handshake          | Payload                                   | Direction
// in      | in_valid/in_stall  | in_item  (data_byte, has_byte, end_of_msg) | into block
// out     | out_valid/out_stall| out_item (digest_word, word_index, last)   | out of block
//
// A byte item is taken while idle; the item that fills a block then compresses it
// (rounds, chaining add). A final item adds one pad byte per cycle to the block end and
// compresses each padded block (two if under 9 bytes are free) and loads the digest words.
// in_stall is high while padding, compressing or loading the digest.
// Reset (rst, synchronous) loads the initial chaining words and clears the length.
// A digest word waits in the output register while out_stall is high; after the last one
// a new message may start.
module sha1_stream_hasher_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1sh_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1sh_pkg::out_item_t out_item
);

  sha1sh_pkg::cmd_t  cmd;
  sha1sh_pkg::stat_t stat;

  // Sequencer
  sha1sh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .has_byte       (in_item.has_byte),
    .end_of_message (in_item.end_of_message),
    .in_stall       (in_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Block buffer, round unit, chaining words and output register
  sha1sh_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hdl/sha1sh_dpath.sv
module sha1sh_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1sh_pkg::cmd_t     cmd,
  input  sha1sh_pkg::in_item_t in_item,
  output sha1sh_pkg::stat_t    stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1sh_pkg::out_item_t out_item
);

  // Block buffer doubles as the message schedule window (word 0 at the top)
  logic [511:0] blk;
  logic [31:0]  chain [sha1sh_pkg::DigestWords];
  logic [31:0]  wa, wb, wc, wd, we;
  logic [60:0]  byte_count;
  logic [5:0]   blk_pos;

  logic [31:0] win0, win2, win8, win13, sched_x, sched_new;
  logic [31:0] f_val, t_val;
  logic [63:0] len_bits, len_shift;
  logic [7:0]  feed;

  // Schedule taps
  assign win0      = blk[511:480];
  assign win2      = blk[447:416];
  assign win8      = blk[255:224];
  assign win13     = blk[95:64];
  assign sched_x   = win13 ^ win8 ^ win2 ^ win0;
  assign sched_new = {sched_x[30:0], sched_x[31]};

  // Round function
  always_comb begin
    case (cmd.round_grp)
      sha1sh_pkg::GRP_CH:  f_val = (wb & wc) | (~wb & wd);
      sha1sh_pkg::GRP_MAJ: f_val = (wb & wc) | (wb & wd) | (wc & wd);
      default:             f_val = wb ^ wc ^ wd;
    endcase
  end

  assign t_val = {wa[26:0], wa[31:27]} + f_val + we
               + sha1sh_pkg::ROUND_K[cmd.round_grp] + win0;

  // Length bytes, most significant first, at block positions 56..63
  assign len_bits  = {byte_count, 3'b000};
  assign len_shift = len_bits >> {~blk_pos[2:0], 3'b000};

  // Byte source
  always_comb begin
    case (cmd.byte_sel)
      sha1sh_pkg::SEL_DATA:  feed = in_item.data_byte;
      sha1sh_pkg::SEL_PAD80: feed = sha1sh_pkg::PAD_BYTE;
      sha1sh_pkg::SEL_LEN:   feed = len_shift[7:0];
      default:               feed = 8'h00;
    endcase
  end

  // Block buffer: byte shift on fill, word shift during rounds
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[503:0], feed};
    end else if (cmd.round_step) begin
      blk <= {blk[479:0], sched_new};
    end
  end

  // Position in block and message length
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      blk_pos    <= '0;
      byte_count <= '0;
    end else begin
      if (cmd.shift) begin
        blk_pos <= blk_pos + 6'd1;
      end
      if (cmd.count) begin
        byte_count <= byte_count + 61'd1;
      end
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < sha1sh_pkg::DigestWords; i++) begin
        chain[i] <= sha1sh_pkg::INIT_CHAIN[i];
      end
    end else if (cmd.fold) begin
      chain[0] <= chain[0] + wa;
      chain[1] <= chain[1] + wb;
      chain[2] <= chain[2] + wc;
      chain[3] <= chain[3] + wd;
      chain[4] <= chain[4] + we;
    end
  end

  // Working registers a..e
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round_step) begin
      wa <= t_val;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.digest_word <= chain[cmd.out_idx];
      out_item.word_index  <= cmd.out_idx;
      out_item.last_word   <= (cmd.out_idx == 3'(sha1sh_pkg::DigestWords - 1));
    end
  end

  assign stat.blk_pos  = blk_pos;
  assign stat.out_full = out_valid && out_stall;

endmodule

>>> hdl/sha1sh_ctrl.sv
module sha1sh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              has_byte,
  input  logic              end_of_message,
  output logic              in_stall,
  input  sha1sh_pkg::stat_t stat,
  output sha1sh_pkg::cmd_t  cmd
);

  localparam logic [6:0] LastRound = 7'(sha1sh_pkg::NumRounds - 1);
  localparam logic [2:0] LastWord  = 3'(sha1sh_pkg::DigestWords - 1);
  localparam logic [5:0] LastPos   = 6'h3F;
  localparam logic [5:0] LenPos    = 6'(sha1sh_pkg::LenStart);

  sha1sh_pkg::state_t state, state_next;
  sha1sh_pkg::state_t ret, ret_next;
  logic [6:0] round_cnt, round_cnt_next;
  logic [2:0] out_idx, out_idx_next;
  logic       sent80, sent80_next;
  logic       len_ok, len_ok_next;
  logic       accept;

  assign in_stall = (state != sha1sh_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1sh_pkg::S_IDLE;
      ret       <= sha1sh_pkg::S_IDLE;
      round_cnt <= '0;
      out_idx   <= '0;
      sent80    <= 1'b0;
      len_ok    <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      round_cnt <= round_cnt_next;
      out_idx   <= out_idx_next;
      sent80    <= sent80_next;
      len_ok    <= len_ok_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    round_cnt_next = round_cnt;
    out_idx_next   = out_idx;
    sent80_next    = sent80;
    len_ok_next    = len_ok;
    cmd            = '0;
    cmd.byte_sel   = sha1sh_pkg::SEL_DATA;
    cmd.round_grp  = sha1sh_pkg::GRP_CH;
    cmd.out_idx    = out_idx;

    case (state)
      sha1sh_pkg::S_IDLE: begin
        if (accept) begin
          sent80_next = 1'b0;
          len_ok_next = 1'b0;
          if (has_byte) begin
            cmd.shift = 1'b1;
            cmd.count = 1'b1;
          end
          if (has_byte && stat.blk_pos == LastPos) begin
            // block full: compress, then pad if this was the final item
            cmd.load_work = 1'b1;
            state_next    = sha1sh_pkg::S_ROUND;
            ret_next      = end_of_message ? sha1sh_pkg::S_PAD : sha1sh_pkg::S_IDLE;
          end else if (end_of_message) begin
            state_next = sha1sh_pkg::S_PAD;
          end
        end
      end

      sha1sh_pkg::S_PAD: begin
        cmd.shift = 1'b1;
        if (!sent80) begin
          cmd.byte_sel = sha1sh_pkg::SEL_PAD80;
          sent80_next  = 1'b1;
          len_ok_next  = (stat.blk_pos < LenPos);
        end else if (len_ok && stat.blk_pos >= LenPos) begin
          cmd.byte_sel = sha1sh_pkg::SEL_LEN;
        end else begin
          cmd.byte_sel = sha1sh_pkg::SEL_ZERO;
        end
        if (stat.blk_pos == LastPos) begin
          cmd.load_work = 1'b1;
          state_next    = sha1sh_pkg::S_ROUND;
          if (cmd.byte_sel == sha1sh_pkg::SEL_LEN) begin
            ret_next = sha1sh_pkg::S_OUT;
          end else begin
            // extra block: the length goes in the next one
            ret_next    = sha1sh_pkg::S_PAD;
            len_ok_next = 1'b1;
          end
        end
      end

      sha1sh_pkg::S_ROUND: begin
        cmd.round_step = 1'b1;
        if (round_cnt < 7'(sha1sh_pkg::GroupRounds)) begin
          cmd.round_grp = sha1sh_pkg::GRP_CH;
        end else if (round_cnt < 7'(2 * sha1sh_pkg::GroupRounds)) begin
          cmd.round_grp = sha1sh_pkg::GRP_PAR1;
        end else if (round_cnt < 7'(3 * sha1sh_pkg::GroupRounds)) begin
          cmd.round_grp = sha1sh_pkg::GRP_MAJ;
        end else begin
          cmd.round_grp = sha1sh_pkg::GRP_PAR2;
        end
        if (round_cnt == LastRound) begin
          round_cnt_next = '0;
          state_next     = sha1sh_pkg::S_FOLD;
        end else begin
          round_cnt_next = round_cnt + 7'd1;
        end
      end

      sha1sh_pkg::S_FOLD: begin
        cmd.fold     = 1'b1;
        out_idx_next = '0;
        state_next   = ret;
      end

      sha1sh_pkg::S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          if (out_idx == LastWord) begin
            // last word captured: back to initial state for next message
            cmd.init     = 1'b1;
            out_idx_next = '0;
            state_next   = sha1sh_pkg::S_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end

      default: begin
        state_next = sha1sh_pkg::S_IDLE;
      end
    endcase
  end

  // Checks
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    round_cnt <= LastRound)
    else $error("round counter out of range");

  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == sha1sh_pkg::S_ROUND && round_cnt == LastRound) |=> state == sha1sh_pkg::S_FOLD)
    else $error("compression did not end after last round");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_full)
    else $error("output register overwritten while stalled");

  a_out_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_idx <= LastWord)
    else $error("digest word index out of range");

  a_work_only_full_block: assert property (@(posedge clk) disable iff (rst)
    cmd.load_work |-> stat.blk_pos == LastPos)
    else $error("compression started on a partial block");

endmodule
